// ----- rtl/core/frwl_pkg.sv -----
// Shared types and constants for the token ring with recent-window lookup.
// No dependencies; imported by the front, back and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package frwl_pkg;

    localparam int RING_DEPTH = 256;
    localparam int TOKEN_BITS = 32;

    localparam int ADDR_W    = $clog2(RING_DEPTH);
    localparam int CNT_W     = $clog2(RING_DEPTH + 1);
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam int Q_DEPTH  = 2;
    localparam int QPTR_W   = $clog2(Q_DEPTH);
    localparam int QFILL_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] CAPACITY_RESET = CFG_W'(256);
    localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(16);

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [TOKEN_BITS-1:0] token;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  cap;
        logic [ADDR_W-1:0] oldest;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/core/frwl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module frwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/core/frwl_front.sv -----
// Front end: accepts input beats, decodes the operation and queues items.
// Depends on frwl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frwl_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_func,
    input  wire logic [frwl_pkg::TOKEN_BITS-1:0] i_token,
    output logic                               o_item_valid,
    output frwl_pkg::t_item                    o_item,
    input  wire logic                          i_item_pop
);

    import frwl_pkg::*;

    t_item              r_q [Q_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QFILL_W-1:0] n_fill;
    t_item              n_item;
    logic               push;
    logic               pop;

    assign o_ready      = (r_fill != QFILL_W'(Q_DEPTH));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd_ptr];

    assign push = i_valid && o_ready;
    assign pop  = i_item_pop && o_item_valid;

    always_comb begin
        n_item.op    = i_func ? OP_QUERY : OP_PUSH;
        n_item.token = i_token;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_fill = r_fill + 1'b1;
        end else if (pop && !push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/frwl_back.sv -----
// Back end: ring state, configuration registers, token store and window search.
// Depends on frwl_pkg and frwl_ram.
`timescale 1ns / 1ps
`default_nettype none

module frwl_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_item_valid,
    input  wire frwl_pkg::t_item                i_item,
    output logic                                o_item_pop,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [frwl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [frwl_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_evicted,
    output logic                                o_resident,
    output frwl_pkg::t_status                   o_status
);

    import frwl_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [ADDR_W-1:0]     r_oldest;
    logic [ADDR_W-1:0]     n_oldest;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic [CNT_W-1:0]      r_cap;
    logic [CNT_W-1:0]      n_cap;
    logic [CFG_W-1:0]      r_window;
    logic [CFG_W-1:0]      n_window;
    logic [ADDR_W-1:0]     r_ptr;
    logic [ADDR_W-1:0]     n_ptr;
    logic [CNT_W-1:0]      r_left;
    logic [CNT_W-1:0]      n_left;
    logic [TOKEN_BITS-1:0] r_key;
    logic [TOKEN_BITS-1:0] n_key;
    logic                  r_res_evicted;
    logic                  n_res_evicted;
    logic                  r_res_resident;
    logic                  n_res_resident;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_out_evicted;
    logic                  n_out_evicted;
    logic                  r_out_resident;
    logic                  n_out_resident;

    logic                  full;
    logic [CNT_W:0]        tail_sum;
    logic [CNT_W:0]        newest_sum;
    logic [ADDR_W-1:0]     tail;
    logic [ADDR_W-1:0]     newest;
    logic [ADDR_W-1:0]     oldest_inc;
    logic [CNT_W-1:0]      span;
    logic [ADDR_W-1:0]     ptr_dec;
    logic                  out_free;
    logic                  cfg_wr;
    logic [CNT_W-1:0]      cap_clamped;

    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [TOKEN_BITS-1:0] rd_data;

    frwl_ram #(
        .WIDTH (TOKEN_BITS),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_item.token),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign full       = (r_count >= r_cap);
    assign tail_sum   = (CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_count);
    assign newest_sum = tail_sum - (CNT_W+1)'(1);
    assign tail       = (tail_sum >= (CNT_W+1)'(r_cap))
                        ? ADDR_W'(tail_sum - (CNT_W+1)'(r_cap)) : ADDR_W'(tail_sum);
    assign newest     = (newest_sum >= (CNT_W+1)'(r_cap))
                        ? ADDR_W'(newest_sum - (CNT_W+1)'(r_cap)) : ADDR_W'(newest_sum);
    assign oldest_inc = ((CNT_W'(r_oldest) + CNT_W'(1)) == r_cap) ? '0 : r_oldest + 1'b1;
    assign span       = (CMP_W'(r_count) < CMP_W'(r_window)) ? r_count : CNT_W'(r_window);
    assign ptr_dec    = (r_ptr == '0) ? ADDR_W'(r_cap - CNT_W'(1)) : r_ptr - 1'b1;
    assign out_free   = !r_out_valid || i_ready;
    assign cfg_wr     = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            cap_clamped = CNT_W'(1);
        end else if (CMP_W'(i_cfg_data) > CMP_W'(RING_DEPTH)) begin
            cap_clamped = CNT_W'(RING_DEPTH);
        end else begin
            cap_clamped = CNT_W'(i_cfg_data);
        end
    end

    always_comb begin
        n_state        = r_state;
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_cap          = r_cap;
        n_window       = r_window;
        n_ptr          = r_ptr;
        n_left         = r_left;
        n_key          = r_key;
        n_res_evicted  = r_res_evicted;
        n_res_resident = r_res_resident;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_evicted  = r_out_evicted;
        n_out_resident = r_out_resident;
        o_item_pop     = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = full ? r_oldest : tail;
        rd_en          = 1'b0;
        rd_addr        = newest;

        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    case (i_item.op)
                        OP_PUSH: begin
                            wr_en          = 1'b1;
                            n_res_evicted  = full;
                            n_res_resident = 1'b0;
                            if (full) begin
                                n_oldest = oldest_inc;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        OP_QUERY: begin
                            n_res_evicted  = 1'b0;
                            n_res_resident = 1'b0;
                            n_key          = i_item.token;
                            if (span == '0) begin
                                n_state = ST_DONE;
                            end else begin
                                rd_en   = 1'b1;
                                n_ptr   = newest;
                                n_left  = span;
                                n_state = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                rd_addr = ptr_dec;
                if (rd_data == r_key) begin
                    n_res_resident = 1'b1;
                    n_state        = ST_DONE;
                end else if (r_left == CNT_W'(1)) begin
                    n_state = ST_DONE;
                end else begin
                    rd_en  = 1'b1;
                    n_ptr  = ptr_dec;
                    n_left = r_left - 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_evicted  = r_res_evicted;
                    n_out_resident = r_res_resident;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // configuration overrides ring state
        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_CAPACITY: begin
                    n_cap    = cap_clamped;
                    n_count  = '0;
                    n_oldest = '0;
                end
                CFG_WINDOW: begin
                    n_window = i_cfg_data;
                end
                default: begin
                    n_window = r_window;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_cap       <= CNT_W'(RING_DEPTH);
            r_window    <= WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_cap       <= n_cap;
            r_window    <= n_window;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr          <= n_ptr;
        r_left         <= n_left;
        r_key          <= n_key;
        r_res_evicted  <= n_res_evicted;
        r_res_resident <= n_res_resident;
        r_out_evicted  <= n_out_evicted;
        r_out_resident <= n_out_resident;
    end

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_evicted       = r_out_evicted;
    assign o_resident      = r_out_resident;
    assign o_status.count  = r_count;
    assign o_status.cap    = r_cap;
    assign o_status.oldest = r_oldest;

endmodule

`default_nettype wire

// ----- rtl/core/fifo_ring_with_window_lookup.sv -----
// Token ring with eviction and recent-window residency lookup, top level.
// Push: item queue, ST_DONE, result register; the back end takes one item at a time.
// Query: searches at most n entries newest first, n = min(entries, window).
// A two-entry item queue lets input beats land while the back end searches.
// Reset empties the ring, sets capacity 256 and window 16; no clearing pass.
// Depends on frwl_pkg, frwl_front, frwl_back and frwl_ram.
`timescale 1ns / 1ps
`default_nettype none

module fifo_ring_with_window_lookup (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_func,
    input  wire logic [frwl_pkg::TOKEN_BITS-1:0] i_token,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic                                o_evicted,
    output logic                                o_resident,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [frwl_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [frwl_pkg::CFG_W-1:0]     i_cfg_data
);

    import frwl_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    item_pop;
    t_status status;

    frwl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_token      (i_token),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    frwl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_evicted    (o_evicted),
        .o_resident   (o_resident),
        .o_status     (status)
    );

    a_count_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= status.cap)
        else $error("entry count above capacity");

    a_oldest_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(status.oldest) < status.cap))
        else $error("oldest position outside ring");

    a_capacity_write_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_CAPACITY)
            |=> (status.count == '0 && status.oldest == '0))
        else $error("capacity write did not empty ring");

    a_single_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_evicted && o_resident))
        else $error("result flags both eviction and residency");

endmodule

`default_nettype wire
